@@ sv/lurt_pkg.sv @@
// Shared widths and defaults for the longest unique run tracker.
`default_nettype none

package lurt_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned LEN_W           = 17;
  localparam int unsigned SYMBOLS         = 256;
  localparam int unsigned DEF_MAX_LEN     = 65536;
  localparam int unsigned DEF_ALPHABET    = 256;

endpackage

`default_nettype wire

@@ sv/lurt_in_if.sv @@
// Input channel: one string byte per transfer.
`default_nettype none

interface lurt_in_if;
  import lurt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              end_of_string;

  modport source (output valid, char_byte, end_of_string, input ready);
  modport sink   (input valid, char_byte, end_of_string, output ready);
endinterface

`default_nettype wire

@@ sv/lurt_out_if.sv @@
// Output channel: one run-length result per transfer.
`default_nettype none

interface lurt_out_if;
  import lurt_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] longest_length;
  logic [LEN_W-1:0] window_length;
  logic             string_done;
  logic             overflow;

  modport source (output valid, longest_length, window_length, string_done, overflow,
                  input ready);
  modport sink   (input valid, longest_length, window_length, string_done, overflow,
                  output ready);
endinterface

`default_nettype wire

@@ sv/lurt_pos_table.sv @@
// Last-position memory with registered read and write-to-read forwarding.
`default_nettype none

module lurt_pos_table #(
  parameter int unsigned MAX_LEN = lurt_pkg::DEF_MAX_LEN,
  parameter int unsigned DEPTH   = lurt_pkg::SYMBOLS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] wr_data_i,
  output logic      [$clog2(MAX_LEN)-1:0] rd_data_o
);
  import lurt_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN);

  logic [PW-1:0] mem_q [DEPTH];
  logic [PW-1:0] rd_q;
  logic          fwd_q;
  logic [PW-1:0] fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // bypass a write that lands on the address being read in the same cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

@@ sv/lurt_window.sv @@
// Window state: seen marks, window start, position, best length and overflow.
`default_nettype none

module lurt_window #(
  parameter int unsigned MAX_LEN = lurt_pkg::DEF_MAX_LEN,
  parameter int unsigned DEPTH   = lurt_pkg::SYMBOLS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       process_i,
  input  wire logic [$clog2(DEPTH)-1:0]   sym_i,
  input  wire logic                       eos_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] last_pos_i,
  output logic                            wr_en_o,
  output logic      [$clog2(DEPTH)-1:0]   wr_addr_o,
  output logic      [$clog2(MAX_LEN)-1:0] wr_data_o,
  output logic      [lurt_pkg::LEN_W-1:0] longest_o,
  output logic      [lurt_pkg::LEN_W-1:0] window_o,
  output logic                            overflow_o
);
  import lurt_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [DEPTH-1:0] seen_q, seen_d;
  logic [PW-1:0]    start_q, start_d;
  logic [LW-1:0]    next_q, next_d;
  logic [LW-1:0]    best_q, best_d;
  logic             ovf_q, ovf_d;

  logic          at_limit;
  logic          hit;
  logic [PW-1:0] start_step;
  logic [LW-1:0] next_step;
  logic [LW-1:0] win_step;
  logic [LW-1:0] win_hold;
  logic [LW-1:0] best_step;

  always_comb begin
    at_limit   = (next_q == LW'(MAX_LEN));
    hit        = seen_q[sym_i] && (last_pos_i >= start_q);
    start_step = hit ? last_pos_i + PW'(1) : start_q;
    next_step  = next_q + LW'(1);
    win_step   = next_step - LW'(start_step);
    win_hold   = next_q - LW'(start_q);
    best_step  = (win_step > best_q) ? win_step : best_q;
  end

  always_comb begin
    seen_d  = seen_q;
    start_d = start_q;
    next_d  = next_q;
    best_d  = best_q;
    ovf_d   = ovf_q;
    if (process_i) begin
      if (at_limit) begin
        ovf_d = 1'b1;
      end else begin
        seen_d[sym_i] = 1'b1;
        start_d       = start_step;
        next_d        = next_step;
        best_d        = best_step;
      end
      if (eos_i) begin
        seen_d  = '0;
        start_d = '0;
        next_d  = '0;
        best_d  = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_comb begin
    wr_en_o    = process_i && !at_limit;
    wr_addr_o  = sym_i;
    wr_data_o  = next_q[PW-1:0];
    longest_o  = at_limit ? LEN_W'(best_q) : LEN_W'(best_step);
    window_o   = at_limit ? LEN_W'(win_hold) : LEN_W'(win_step);
    overflow_o = at_limit || ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      start_q <= '0;
      next_q  <= '0;
      best_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      start_q <= start_d;
      next_q  <= next_d;
      best_q  <= best_d;
      ovf_q   <= ovf_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) LW'(start_q) <= next_q)
    else $error("window start passed the next position");
  assert property (@(posedge clk_i) disable iff (!rst_ni) next_q <= LW'(MAX_LEN))
    else $error("position counter beyond saturation");
  assert property (@(posedge clk_i) disable iff (!rst_ni) best_q >= win_hold)
    else $error("best length below current window");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    process_i && eos_i |=> (seen_q == '0) && (next_q == '0) && (best_q == '0) && !ovf_q)
    else $error("string state not cleared after final byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovf_q |-> at_limit)
    else $error("overflow set below the length limit");
`endif

endmodule

`default_nettype wire

@@ sv/longest_unique_run_tracker.sv @@
// Top level: longest repeat-free run tracker over a byte stream.
//
//   channel  modport            transfer carries
//   in_i     lurt_in_if.sink    char_byte, end_of_string
//   out_o    lurt_out_if.source longest_length, window_length, string_done, overflow
//
// One byte per cycle while out_o is ready; results pass the lookup and output registers.
// Throughput is set by one read-modify-write of the last-position memory per byte,
// with a same-address write forwarded into the following read.
// Reset clears the seen marks (flip-flops) and counters at once; no clearing pass.
// A stalled output holds its result; the lookup stage still takes one more byte.
`default_nettype none

module longest_unique_run_tracker #(
  parameter int unsigned MAX_LEN  = lurt_pkg::DEF_MAX_LEN,
  parameter int unsigned ALPHABET = lurt_pkg::DEF_ALPHABET
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lurt_in_if.sink     in_i,
  lurt_out_if.source  out_o
);
  import lurt_pkg::*;

  localparam int unsigned DEPTH = (ALPHABET < SYMBOLS) ? ALPHABET : SYMBOLS;
  localparam int unsigned SW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(MAX_LEN);

  logic [SW-1:0] fold_tbl [SYMBOLS];

  for (genvar g = 0; g < SYMBOLS; g++) begin : g_fold
    localparam int unsigned Folded = g % ALPHABET;
    assign fold_tbl[g] = SW'(Folded);
  end

  logic             in_fire;
  logic             s1_fire;
  logic [SW-1:0]    in_sym;
  logic             s1_valid_q;
  logic [SW-1:0]    s1_sym_q;
  logic             s1_eos_q;
  logic             out_valid_q;
  logic [LEN_W-1:0] out_longest_q;
  logic [LEN_W-1:0] out_window_q;
  logic             out_done_q;
  logic             out_ovf_q;

  logic             wr_en;
  logic [SW-1:0]    wr_addr;
  logic [PW-1:0]    wr_data;
  logic [PW-1:0]    last_pos;
  logic [LEN_W-1:0] res_longest;
  logic [LEN_W-1:0] res_window;
  logic             res_ovf;

  always_comb begin
    s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
    in_i.ready = !s1_valid_q || s1_fire;
    in_fire    = in_i.valid && in_i.ready;
    in_sym     = fold_tbl[in_i.char_byte];
  end

  lurt_pos_table #(
    .MAX_LEN (MAX_LEN),
    .DEPTH   (DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_sym),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (last_pos)
  );

  lurt_window #(
    .MAX_LEN (MAX_LEN),
    .DEPTH   (DEPTH)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .process_i  (s1_fire),
    .sym_i      (s1_sym_q),
    .eos_i      (s1_eos_q),
    .last_pos_i (last_pos),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .longest_o  (res_longest),
    .window_o   (res_window),
    .overflow_o (res_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sym_q <= in_sym;
      s1_eos_q <= in_i.end_of_string;
    end
    if (s1_fire) begin
      out_longest_q <= res_longest;
      out_window_q  <= res_window;
      out_done_q    <= s1_eos_q;
      out_ovf_q     <= res_ovf;
    end
  end

  always_comb begin
    out_o.valid          = out_valid_q;
    out_o.longest_length = out_longest_q;
    out_o.window_length  = out_window_q;
    out_o.string_done    = out_done_q;
    out_o.overflow       = out_ovf_q;
  end

endmodule

`default_nettype wire

@@ bench/longest_unique_run_tracker_test.sv @@
// Self-checking bench for the longest unique run tracker: directed and random strings, gaps.
`default_nettype none

module longest_unique_run_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lurt_pkg::*;

  localparam int unsigned RUN_MAX_LEN  = DEF_MAX_LEN;
  localparam int unsigned RUN_ALPHABET = DEF_ALPHABET;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef enum int {
    GAPS_NONE,
    GAPS_SPARSE,
    GAPS_NORMAL
  } gap_level_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RAMP,
    FILL_CYCLE
  } fill_style_e;

  typedef struct packed {
    logic [LEN_W-1:0] longest;
    logic [LEN_W-1:0] window;
    logic             done;
    logic             ovf;
  } run_result_t;

  class run_length_board;
    int unsigned last_pos [SYMBOLS];
    bit          seen     [SYMBOLS];
    int unsigned win_start;
    int unsigned next_pos;
    int unsigned best_len;
    bit          ovf_flag;
    run_result_t expected_runs[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (seen[i]) seen[i] = 1'b0;
      win_start = 0;
      next_pos  = 0;
      best_len  = 0;
      ovf_flag  = 1'b0;
    endfunction

    function void note_byte(logic [CHAR_W-1:0] ch, logic eos);
      int unsigned sym;
      run_result_t r;
      sym = int'(ch) % RUN_ALPHABET;
      if (next_pos >= RUN_MAX_LEN) begin
        ovf_flag = 1'b1;
      end else begin
        if (seen[sym] && last_pos[sym] >= win_start) begin
          win_start = last_pos[sym] + 1;
        end
        last_pos[sym] = next_pos;
        seen[sym]     = 1'b1;
        next_pos      = next_pos + 1;
        if (next_pos - win_start > best_len) begin
          best_len = next_pos - win_start;
        end
      end
      r.longest = LEN_W'(best_len);
      r.window  = LEN_W'(next_pos - win_start);
      r.done    = eos;
      r.ovf     = ovf_flag;
      expected_runs.push_back(r);
      if (eos) begin
        clear_string();
      end
    endfunction

    function void check_result(run_result_t got);
      run_result_t want;
      if (expected_runs.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected result: longest=%0d window=%0d done=%0b ovf=%0b",
                   got.longest, got.window, got.done, got.ovf);
        end
      end else begin
        want = expected_runs.pop_front();
        if (want !== got) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display({"mismatch: expected longest=%0d window=%0d done=%0b ovf=%0b,",
                      " got longest=%0d window=%0d done=%0b ovf=%0b"},
                     want.longest, want.window, want.done, want.ovf,
                     got.longest, got.window, got.done, got.ovf);
          end
        end
      end
    endfunction

    function int unsigned pending_count();
      return expected_runs.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lurt_in_if  in_ch();
  lurt_out_if out_ch();

  longest_unique_run_tracker #(
    .MAX_LEN  (RUN_MAX_LEN),
    .ALPHABET (RUN_ALPHABET)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  run_length_board board;
  gap_level_e      gap_level;
  int unsigned     items_sent;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (gap_level)
      GAPS_NONE: begin
        return 0;
      end
      GAPS_SPARSE: begin
        return (r < 2) ? $urandom_range(1, 3) : 0;
      end
      default: begin
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic eos);
    int unsigned gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.char_byte <= CHAR_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.char_byte     <= ch;
    in_ch.end_of_string <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_byte(ch, eos);
    items_sent++;
  endtask

  task automatic send_pattern(input logic [CHAR_W-1:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic send_string(input int unsigned len, input fill_style_e style);
    logic [CHAR_W-1:0] base;
    int unsigned span;
    int unsigned period;
    logic [CHAR_W-1:0] ch;
    base   = CHAR_W'($urandom);
    span   = $urandom_range(1, 15);
    period = $urandom_range(2, 300);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        FILL_NARROW: ch = base + CHAR_W'($urandom_range(0, span));
        FILL_RAMP:   ch = base + CHAR_W'(i);
        FILL_CYCLE:  ch = base + CHAR_W'(i % period);
        default:     ch = CHAR_W'($urandom);
      endcase
      send_byte(ch, i == len - 1);
    end
  endtask

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    run_result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.longest = out_ch.longest_length;
        got.window  = out_ch.window_length;
        got.done    = out_ch.string_done;
        got.ovf     = out_ch.overflow;
        board.check_result(got);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("longest_unique_run_tracker_test: FAIL");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned pick;
    board      = new();
    items_sent = 0;
    gap_level  = GAPS_NONE;
    in_ch.valid         = 1'b0;
    in_ch.char_byte     = '0;
    in_ch.end_of_string = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_pattern('{8'h00});
    send_pattern('{8'hFF});
    send_pattern('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63, 8'h62, 8'h62});
    send_pattern('{8'h55, 8'hAA, 8'hAA, 8'h55});
    send_pattern('{8'h07, 8'h07, 8'h07});
    gap_level = GAPS_NORMAL;
    send_pattern('{8'h80, 8'h01, 8'h80});

    while (items_sent < RANDOM_ITEMS) begin
      gap_level = ($urandom_range(0, 4) == 0) ? GAPS_NONE : GAPS_NORMAL;
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 12);
      else if (pick < 9) len = $urandom_range(13, 64);
      else len = $urandom_range(65, 400);
      send_string(len, fill_style_e'($urandom_range(0, 3)));
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    gap_level = GAPS_NONE;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending_count() == 0) begin
      $display("longest_unique_run_tracker_test: PASS");
    end else begin
      $display("longest_unique_run_tracker_test: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
